// ===== rtl/qccs_pkg.sv =====
// ---------------------------------------------------------------------------
// qccs_pkg
// Shared constants, pipeline payload type and square-root step function for
// the quarter-circle corner span generator.
// ---------------------------------------------------------------------------
package qccs_pkg;

  localparam int COORD_BITS    = 9;
  localparam int MAX_RADIUS    = 63;
  localparam int RAD_W         = $clog2(MAX_RADIUS + 1);
  localparam int POS_W         = COORD_BITS + 1;
  localparam int COLR_W        = 16;
  // radicand r*r fits in 2*RAD_W bits; two spare bits keep root + bit in range
  localparam int SQ_W          = 2 * RAD_W + 2;
  localparam int ROOT_STEPS    = RAD_W + 1;
  localparam int STEPS_PER_STG = 2;
  localparam int ROOT_STGS     = (ROOT_STEPS + STEPS_PER_STG - 1) / STEPS_PER_STG;
  // issue stage, radicand stage, then the root stages
  localparam int NSTG          = 2 + ROOT_STGS;

  typedef struct packed {
    logic [POS_W-1:0]      col;
    logic [COORD_BITS-1:0] oy;
    logic [RAD_W-1:0]      rad;
    logic [RAD_W-1:0]      ofs;
    logic                  top;
    logic [COLR_W-1:0]     colour;
    logic                  last;
    logic [SQ_W-1:0]       rem;
    logic [SQ_W-1:0]       root;
  } span_pipe_t;

  // one digit of the restoring square root; step 0 uses the top test bit
  function automatic span_pipe_t root_step(span_pipe_t p, int step);
    logic [SQ_W-1:0] rbit;
    logic [SQ_W-1:0] trial;
    span_pipe_t      q;
    rbit  = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - step));
    trial = p.root + rbit;
    q     = p;
    if (p.rem >= trial) begin
      q.rem  = p.rem - trial;
      q.root = (p.root >> 1) + rbit;
    end else begin
      q.root = p.root >> 1;
    end
    return q;
  endfunction

endpackage

// ===== rtl/quarter_circle_corner_spans.sv =====
// ---------------------------------------------------------------------------
// quarter_circle_corner_spans
// Turns one corner descriptor into radius+1 vertical fill spans that cover
// the area between a quarter circle and its bounding square.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one corner beat: origin, radius,
//   top/bottom and left/right flags and a colour. Output channel
//   (out_valid/out_ready) returns radius+1 span beats, last_span set on the
//   final one.
//   A sequencer holds the corner and issues one column offset per cycle,
//   unless the output stalls, into a pipeline: radicand r*r-i*i, then a
//   restoring square root two digits per stage, then the span geometry into
//   the output register.
//   Throughput: one span per cycle while the receiver takes them; in_ready is
//   low while a corner's radius+1 column offsets are being issued.
//   Receiver stall: when out_ready is low with a span waiting, the whole
//   pipeline and the sequencer's offset freeze, though an idle sequencer can
//   still take a new corner; nothing is dropped or repeated.
//   Reset (rst, synchronous): clears the sequencer and all valid bits; the
//   block comes up idle with in_ready high.
// ---------------------------------------------------------------------------
module quarter_circle_corner_spans (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [qccs_pkg::COORD_BITS-1:0] origin_x,
  input  logic [qccs_pkg::COORD_BITS-1:0] origin_y,
  input  logic [qccs_pkg::RAD_W-1:0]      corner_radius,
  input  logic                            is_top,
  input  logic                            is_left,
  input  logic [qccs_pkg::COLR_W-1:0]     fill_colour,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [qccs_pkg::POS_W-1:0]      span_x,
  output logic [qccs_pkg::POS_W-1:0]      span_top,
  output logic [qccs_pkg::RAD_W-1:0]      span_length,
  output logic [qccs_pkg::COLR_W-1:0]     span_colour,
  output logic                            last_span
);

  // held corner
  logic [qccs_pkg::COORD_BITS-1:0] ox;
  logic [qccs_pkg::COORD_BITS-1:0] oy;
  logic [qccs_pkg::RAD_W-1:0]      rad;
  logic                            top;
  logic                            left;
  logic [qccs_pkg::COLR_W-1:0]     colour;
  logic [qccs_pkg::RAD_W-1:0]      ofs;
  logic                            busy;

  qccs_pkg::span_pipe_t stg      [qccs_pkg::NSTG];
  qccs_pkg::span_pipe_t stg_next [qccs_pkg::NSTG];
  logic [qccs_pkg::NSTG-1:0] vld;

  logic adv;
  logic in_beat;
  logic [qccs_pkg::SQ_W-1:0] h;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !busy;
  assign in_beat  = in_valid && in_ready;

  function automatic logic [qccs_pkg::POS_W-1:0] is_left_col(
    logic [qccs_pkg::COORD_BITS-1:0] x0,
    logic [qccs_pkg::RAD_W-1:0]      r,
    logic [qccs_pkg::RAD_W-1:0]      i,
    logic                            lft
  );
    logic [qccs_pkg::POS_W-1:0] c;
    if (lft) begin
      c = qccs_pkg::POS_W'(x0) + qccs_pkg::POS_W'(r) - qccs_pkg::POS_W'(i);
    end else begin
      c = qccs_pkg::POS_W'(x0) + qccs_pkg::POS_W'(i);
    end
    return c;
  endfunction

  always_comb begin
    // issue stage
    stg_next[0].col    = is_left_col(ox, rad, ofs, left);
    stg_next[0].oy     = oy;
    stg_next[0].rad    = rad;
    stg_next[0].ofs    = ofs;
    stg_next[0].top    = top;
    stg_next[0].colour = colour;
    stg_next[0].last   = (ofs == rad);
    stg_next[0].rem    = '0;
    stg_next[0].root   = '0;
    // radicand stage
    stg_next[1]     = stg[0];
    stg_next[1].rem = qccs_pkg::SQ_W'(stg[0].rad) * qccs_pkg::SQ_W'(stg[0].rad)
                    - qccs_pkg::SQ_W'(stg[0].ofs) * qccs_pkg::SQ_W'(stg[0].ofs);
    stg_next[1].root = '0;
    // root stages
    for (int k = 2; k < qccs_pkg::NSTG; k++) begin
      stg_next[k] = stg[k-1];
      for (int j = 0; j < qccs_pkg::STEPS_PER_STG; j++) begin
        if ((k - 2) * qccs_pkg::STEPS_PER_STG + j < qccs_pkg::ROOT_STEPS) begin
          stg_next[k] = qccs_pkg::root_step(stg_next[k],
                                            (k - 2) * qccs_pkg::STEPS_PER_STG + j);
        end
      end
    end
  end

  assign h = stg[qccs_pkg::NSTG-1].root;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ofs  <= '0;
    end else if (in_beat) begin
      busy <= 1'b1;
      ofs  <= '0;
    end else if (busy && adv) begin
      ofs <= ofs + 1'b1;
      if (ofs == rad) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      ox     <= origin_x;
      oy     <= origin_y;
      rad    <= corner_radius;
      top    <= is_top;
      left   <= is_left;
      colour <= fill_colour;
    end
  end

  // pipeline stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[qccs_pkg::NSTG-2:0], busy};
      out_valid <= vld[qccs_pkg::NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < qccs_pkg::NSTG; k++) begin
        stg[k] <= stg_next[k];
      end
      span_x      <= stg[qccs_pkg::NSTG-1].col;
      span_top    <= stg[qccs_pkg::NSTG-1].top
                   ? qccs_pkg::POS_W'(stg[qccs_pkg::NSTG-1].oy)
                   : qccs_pkg::POS_W'(stg[qccs_pkg::NSTG-1].oy) + qccs_pkg::POS_W'(h);
      span_length <= stg[qccs_pkg::NSTG-1].rad - h[qccs_pkg::RAD_W-1:0];
      span_colour <= stg[qccs_pkg::NSTG-1].colour;
      last_span   <= stg[qccs_pkg::NSTG-1].last;
    end
  end

  // assertions
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> busy && ofs == '0)
    else $error("corner not started after input beat");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    busy && adv && ofs == rad |=> !busy)
    else $error("sequencer overran the radius");

  // a new corner may still be taken while the output stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv && !in_beat |=> $stable(vld) && $stable(ofs))
    else $error("pipeline moved during a stall");

endmodule
